// ----- src/ppc_pkg.sv -----
// ----------------------------------------------------------------------------
// ppc_pkg: shared types and constants for the pulse position decoder
// Request payloads, register indexes, reset values and pipeline enables.
// ----------------------------------------------------------------------------
package ppc_pkg;

    // Default pulse width that maps to zero before the offset (timer counts)
    localparam int unsigned CENTER_COUNTS_DEF = 36000;

    // Configuration port
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_GAIN       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_STEP   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ARM_PULSES = 3'd4;

    // Register reset values
    localparam logic signed [31:0] GAIN_RST       = 32'sd65536;
    localparam logic signed [31:0] OFFSET_RST     = 32'sd0;
    localparam logic [30:0]        MAX_STEP_RST   = 31'd256000;
    localparam logic [30:0]        TIMEOUT_RST    = 31'd100000;
    localparam logic [7:0]         ARM_PULSES_RST = 8'd10;

    // Input request
    typedef struct packed {
        logic [31:0]        time_now;
        logic               period_seen;
        logic [15:0]        pulse_width;
        logic signed [31:0] present_position;
    } in_item_t;

    // Result request
    typedef struct packed {
        logic               load_reference;
        logic signed [31:0] reference_position;
        logic               timing_trigger;
        logic               enter_idle;
        logic               armed;
    } out_item_t;

    // Per-stage load enables for the mapping datapath
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } adv_t;

endpackage

// ----- src/pwm_pulse_position_command_top.sv -----
// ----------------------------------------------------------------------------
// pwm_pulse_position_command_top: RC servo pulse position command decoder
// Turns captured pulse periods and widths into reference loads, timing
// triggers and idle requests, with arming count and silence timeout.
// ----------------------------------------------------------------------------
//  channel   signals                              direction
//  input     in_valid / in_ready / in_data        request in
//  result    out_valid / out_ready / out_data     request out
//  config    cfg_wr_en / cfg_index / cfg_wdata    write only
//
//  Throughput is one request per cycle while the result is not stalled; a
//  result passes the input register, product register, saturate register
//  and result register before it is offered. Pulse count and last pulse
//  time update as a request leaves the input register. Reset clears the
//  count and time and loads register defaults. A stalled result holds;
//  ready falls once all four stages are full and the result is stalled.
// ----------------------------------------------------------------------------
module pwm_pulse_position_command_top #(
    parameter int unsigned CENTER_COUNTS = ppc_pkg::CENTER_COUNTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ppc_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output ppc_pkg::out_item_t                  out_data,
    input  logic                                cfg_wr_en,
    input  logic [ppc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ppc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    typedef struct packed {
        logic load;
        logic trig;
        logic idle;
        logic armed;
    } flags_t;

    // Configuration registers
    logic signed [31:0] gain_reg;
    logic signed [31:0] offset_reg;
    logic [30:0]        max_step_reg;
    logic [30:0]        timeout_reg;
    logic [7:0]         arm_reg;

    // Decoder state
    logic [7:0]  pulse_count_reg;
    logic [7:0]  pulse_count_next;
    logic [31:0] last_time_reg;
    logic [31:0] last_time_next;

    // Pipeline
    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    logic              ready2, ready3, ready4;
    ppc_pkg::in_item_t in_item_reg;
    ppc_pkg::adv_t     adv;
    flags_t            flags_next;
    flags_t            flags2_reg, flags3_reg, flags4_reg;
    logic              use_map;
    logic signed [31:0] reference_position;

    logic        glitch;
    logic        has_width;
    logic [31:0] gap;
    logic        timed_out;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg     <= ppc_pkg::GAIN_RST;
            offset_reg   <= ppc_pkg::OFFSET_RST;
            max_step_reg <= ppc_pkg::MAX_STEP_RST;
            timeout_reg  <= ppc_pkg::TIMEOUT_RST;
            arm_reg      <= ppc_pkg::ARM_PULSES_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                ppc_pkg::REG_GAIN:       gain_reg     <= $signed(cfg_wdata);
                ppc_pkg::REG_OFFSET:     offset_reg   <= $signed(cfg_wdata);
                ppc_pkg::REG_MAX_STEP:   max_step_reg <= cfg_wdata[30:0];
                ppc_pkg::REG_TIMEOUT:    timeout_reg  <= cfg_wdata[30:0];
                ppc_pkg::REG_ARM_PULSES: arm_reg      <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Advance a stage when its successor is empty or moving
    assign ready4   = !v4_reg || out_ready;
    assign ready3   = !v3_reg || ready4;
    assign ready2   = !v2_reg || ready3;
    assign in_ready = !v1_reg || ready2;

    assign adv.s2 = v1_reg && ready2;
    assign adv.s3 = v2_reg && ready3;
    assign adv.s4 = v3_reg && ready4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                v1_reg <= in_valid;
            if (ready2)
                v2_reg <= v1_reg;
            if (ready3)
                v3_reg <= v2_reg;
            if (ready4)
                v4_reg <= v3_reg;
        end
    end

    // Hold the accepted request
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_data;
    end

    // Classify the poll and work out the next decoder state
    assign glitch    = in_item_reg.period_seen && (in_item_reg.pulse_width != 16'd0);
    assign has_width = in_item_reg.pulse_width != 16'd0;
    assign gap       = in_item_reg.time_now - last_time_reg;
    assign timed_out = !in_item_reg.period_seen && !has_width
                       && ($signed(33'(signed'(gap))) > $signed({2'b00, timeout_reg}));
    assign use_map   = has_width && !glitch;

    always_comb
    begin
        pulse_count_next = pulse_count_reg;
        last_time_next   = last_time_reg;
        flags_next       = '0;
        if (glitch)
        begin
            pulse_count_next = 8'd0;
        end
        else
        begin
            if (in_item_reg.period_seen)
            begin
                flags_next.trig = 1'b1;
                last_time_next  = in_item_reg.time_now;
            end
            if (has_width)
            begin
                if (pulse_count_reg >= arm_reg)
                    flags_next.load = 1'b1;
                else
                    pulse_count_next = pulse_count_reg + 8'd1;
            end
            else if (timed_out)
            begin
                flags_next.idle  = 1'b1;
                pulse_count_next = 8'd0;
                last_time_next   = in_item_reg.time_now;
            end
        end
        flags_next.armed = pulse_count_next >= arm_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_count_reg <= 8'd0;
            last_time_reg   <= 32'd0;
        end
        else if (adv.s2)
        begin
            pulse_count_reg <= pulse_count_next;
            last_time_reg   <= last_time_next;
        end
    end

    // Carry flags alongside the mapping datapath
    always_ff @(posedge clk)
    begin
        if (adv.s2)
            flags2_reg <= flags_next;
        if (adv.s3)
            flags3_reg <= flags2_reg;
        if (adv.s4)
            flags4_reg <= flags3_reg;
    end

    ppc_map #(
        .CENTER_COUNTS (CENTER_COUNTS)
    ) u_map (
        .clk                (clk),
        .adv                (adv),
        .use_map            (use_map),
        .pulse_width        (in_item_reg.pulse_width),
        .present_position   (in_item_reg.present_position),
        .gain               (gain_reg),
        .position_offset    (offset_reg),
        .max_step           (max_step_reg),
        .reference_position (reference_position)
    );

    // Assemble the result request
    always_comb
    begin
        out_data.load_reference     = flags4_reg.load;
        out_data.reference_position = reference_position;
        out_data.timing_trigger     = flags4_reg.trig;
        out_data.enter_idle         = flags4_reg.idle;
        out_data.armed              = flags4_reg.armed;
    end

    assign out_valid = v4_reg;

`ifndef SYNTHESIS
    // A load only happens once the count has reached the arming level
    a_load_armed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.load_reference) |-> out_data.armed)
        else $error("reference load without armed");

    // Idle and load come from exclusive branches
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.load_reference && out_data.enter_idle))
        else $error("load and idle together");

    // Period with width is a glitch, so trigger and load never coincide
    a_trig_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.timing_trigger && out_data.load_reference))
        else $error("trigger and load together");

    // An idle request always leaves the counter cleared
    a_idle_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (adv.s2 && flags_next.idle) |=> (pulse_count_reg == 8'd0))
        else $error("idle without counter clear");
`endif

endmodule

// ----- src/ppc_map.sv -----
// ----------------------------------------------------------------------------
// ppc_map: pulse width to clamped reference position
// Three register stages: multiply, round/offset/saturate, step clamp.
// ----------------------------------------------------------------------------
module ppc_map #(
    parameter int unsigned CENTER_COUNTS = ppc_pkg::CENTER_COUNTS_DEF
) (
    input  logic               clk,
    input  ppc_pkg::adv_t      adv,
    input  logic               use_map,
    input  logic [15:0]        pulse_width,
    input  logic signed [31:0] present_position,
    input  logic signed [31:0] gain,
    input  logic signed [31:0] position_offset,
    input  logic [30:0]        max_step,
    output logic signed [31:0] reference_position
);

    localparam logic signed [16:0] CENTER   = 17'(CENTER_COUNTS);
    localparam logic signed [42:0] SAT_HIGH = 43'sd2147483647;
    localparam logic signed [42:0] SAT_LOW  = -43'sd2147483648;

    logic signed [16:0] delta;
    logic signed [48:0] prod_next;
    logic signed [48:0] prod_reg;
    logic signed [31:0] present2_reg;
    logic               use2_reg;

    logic signed [49:0] round_sum;
    logic signed [41:0] scaled;
    logic signed [42:0] offset_sum;
    logic signed [31:0] pos_next;
    logic signed [31:0] pos_reg;
    logic signed [31:0] present3_reg;
    logic               use3_reg;

    logic signed [32:0] step;
    logic signed [32:0] limit;
    logic signed [32:0] step_clamped;
    logic signed [32:0] target;
    logic signed [31:0] ref_next;
    logic signed [31:0] ref_reg;

    // Signed offset from centre, then Q.16 product
    assign delta     = $signed({1'b0, pulse_width}) - CENTER;
    assign prod_next = 49'(delta) * 49'(gain);

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            prod_reg     <= prod_next;
            present2_reg <= present_position;
            use2_reg     <= use_map;
        end
    end

    // Round to Q.8 (halves upward), add offset, saturate to 32 bits
    assign round_sum  = 50'(prod_reg) + 50'sd128;
    assign scaled     = $signed(round_sum[49:8]);
    assign offset_sum = 43'(scaled) + 43'(position_offset);

    always_comb
    begin
        if (offset_sum > SAT_HIGH)
            pos_next = 32'sh7fffffff;
        else if (offset_sum < SAT_LOW)
            pos_next = 32'sh80000000;
        else
            pos_next = $signed(offset_sum[31:0]);
    end

    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            pos_reg      <= pos_next;
            present3_reg <= present2_reg;
            use3_reg     <= use2_reg;
        end
    end

    // Limit the step from the present position
    assign step  = 33'(pos_reg) - 33'(present3_reg);
    assign limit = $signed({2'b00, max_step});

    always_comb
    begin
        if (step > limit)
            step_clamped = limit;
        else if (step < -limit)
            step_clamped = -limit;
        else
            step_clamped = step;
    end

    assign target   = 33'(present3_reg) + step_clamped;
    assign ref_next = use3_reg ? $signed(target[31:0]) : 32'sd0;

    always_ff @(posedge clk)
    begin
        if (adv.s4)
            ref_reg <= ref_next;
    end

    assign reference_position = ref_reg;

endmodule
